>>> src/hss_pkg.sv
// Shared types, constants and the coil pattern table of the half-step stepper sequencer.
// No dependencies; every other file imports this package.
package hss_pkg;

  localparam int MODE_W        = 2;
  localparam int MOVE_STEPS_W  = 16;
  localparam int COILS_W       = 4;
  localparam int POSITION_W    = 32;
  localparam int REMAINING_W   = 16;
  localparam int PHASE_W       = 3;
  localparam int DEFAULT_MOVE_COUNT_BITS = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2,
    MODE_MOVE  = 2'd3
  } hss_mode_t;

  // One result beat, as handed from the state unit to the output register.
  typedef struct packed {
    logic [COILS_W-1:0]            coils;
    logic signed [POSITION_W-1:0]  position;
    logic [REMAINING_W-1:0]        remaining;
    logic                          moving;
    logic                          stepped;
  } hss_result_t;

  // Half-step coil pattern for each phase: 9,1,3,2,6,4,12,8.
  function automatic logic [COILS_W-1:0] coil_pattern(input logic [PHASE_W-1:0] phase);
    logic [COILS_W-1:0] pat;
    case (phase)
      3'd0:    pat = 4'd9;
      3'd1:    pat = 4'd1;
      3'd2:    pat = 4'd3;
      3'd3:    pat = 4'd2;
      3'd4:    pat = 4'd6;
      3'd5:    pat = 4'd4;
      3'd6:    pat = 4'd12;
      default: pat = 4'd8;
    endcase
    return pat;
  endfunction

endpackage

>>> src/hss_channels.sv
// Valid/ready channel interfaces for command beats and result beats.
// Depends on hss_pkg for field widths.
interface hss_cmd_if;
  import hss_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic                     dir;
  logic [MOVE_STEPS_W-1:0]  move_steps;

  modport source (output valid, output mode, output dir, output move_steps, input ready);
  modport sink   (input valid, input mode, input dir, input move_steps, output ready);
endinterface

interface hss_res_if;
  import hss_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [COILS_W-1:0]            coils;
  logic signed [POSITION_W-1:0]  position;
  logic [REMAINING_W-1:0]        remaining;
  logic                          moving;
  logic                          stepped;

  modport source (output valid, output coils, output position, output remaining,
                  output moving, output stepped, input ready);
  modport sink   (input valid, input coils, input position, input remaining,
                  input moving, input stepped, output ready);
endinterface

>>> src/hss_motor_state.sv
// Motor state registers (phase, position, count, mode, direction, coils) and
// their per-command update. Depends on hss_pkg.
module hss_motor_state
  import hss_pkg::*;
#(
  parameter int MOVE_COUNT_BITS = DEFAULT_MOVE_COUNT_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     fire,
  input  logic [MODE_W-1:0]        mode,
  input  logic                     dir,
  input  logic [MOVE_STEPS_W-1:0]  move_steps,
  output hss_result_t              res_nxt
);

  logic [PHASE_W-1:0]           phase_r,  phase_nxt;
  logic signed [POSITION_W-1:0] pos_r,    pos_nxt;
  logic [MOVE_COUNT_BITS-1:0]   left_r,   left_nxt;
  logic                         cont_r,   cont_nxt;
  logic                         ccw_r,    ccw_nxt;
  logic [COILS_W-1:0]           coils_r,  coils_nxt;
  logic                         stepped;
  logic                         busy;

  assign busy = cont_r || (left_r != '0);

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    left_nxt  = left_r;
    cont_nxt  = cont_r;
    ccw_nxt   = ccw_r;
    coils_nxt = coils_r;
    stepped   = 1'b0;
    case (mode)
      MODE_TICK: begin
        if (busy) begin
          // Drive the current phase, then advance
          coils_nxt = coil_pattern(phase_r);
          stepped   = 1'b1;
          if (ccw_r) begin
            phase_nxt = phase_r - 1'b1;
            pos_nxt   = pos_r - 32'sd1;
          end else begin
            phase_nxt = phase_r + 1'b1;
            pos_nxt   = pos_r + 32'sd1;
          end
          if (left_r != '0) begin
            left_nxt = left_r - 1'b1;
          end
        end
      end
      MODE_START: begin
        ccw_nxt  = dir;
        cont_nxt = 1'b1;
      end
      MODE_STOP: begin
        cont_nxt = 1'b0;
        left_nxt = '0;
      end
      MODE_MOVE: begin
        ccw_nxt  = dir;
        left_nxt = MOVE_COUNT_BITS'(move_steps);
      end
      default: begin
        stepped = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_nxt.coils     = coils_nxt;
    res_nxt.position  = pos_nxt;
    res_nxt.remaining = REMAINING_W'(left_nxt);
    res_nxt.moving    = cont_nxt || (left_nxt != '0);
    res_nxt.stepped   = stepped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      pos_r   <= '0;
      left_r  <= '0;
      cont_r  <= 1'b0;
      ccw_r   <= 1'b0;
      coils_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      left_r  <= left_nxt;
      cont_r  <= cont_nxt;
      ccw_r   <= ccw_nxt;
      coils_r <= coils_nxt;
    end
  end

endmodule

>>> src/half_step_stepper_sequencer.sv
// Top level of the half-step stepper sequencer: command channel in, result channel out.
// Depends on hss_pkg, hss_channels (hss_cmd_if, hss_res_if) and hss_motor_state.
//
// Usage:
//   in_bus carries one command per beat: tick, start continuous, stop, or
//   move by a step count, with a direction for start and move.
//   out_bus returns exactly one result beat per command: coil levels, signed
//   position, remaining count, moving flag and whether this beat stepped.
//   The result of a command is registered and is valid right after the edge
//   that accepts it. Throughput is one command per cycle while the receiver
//   takes each result; the state update for a command is a single pass of
//   logic between the command handshake and the result register.
//   While the receiver stalls, the result register holds its beat and the
//   command channel is ready only in the cycle the held beat is taken, so
//   a new command may enter in the same cycle the old result leaves.
//   Synchronous reset clears the phase, position, count, continuous mode,
//   direction (clockwise) and coils (all off), and empties the result
//   register. The command channel is ready in the first cycle after reset.
module half_step_stepper_sequencer
  import hss_pkg::*;
#(
  parameter int MOVE_COUNT_BITS = DEFAULT_MOVE_COUNT_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  hss_cmd_if.sink    in_bus,
  hss_res_if.source  out_bus
);

  hss_result_t res_nxt;
  hss_result_t res_r;
  logic        out_valid_r;
  logic        fire;

  // Accept a command whenever the result slot is empty or being drained
  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign fire         = in_bus.valid && in_bus.ready;

  hss_motor_state #(
    .MOVE_COUNT_BITS (MOVE_COUNT_BITS)
  ) u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .mode       (in_bus.mode),
    .dir        (in_bus.dir),
    .move_steps (in_bus.move_steps),
    .res_nxt    (res_nxt)
  );

  // Valid flag: set on a command beat, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload: load with each command's result, hold while stalled
  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.coils     = res_r.coils;
  assign out_bus.position  = res_r.position;
  assign out_bus.remaining = res_r.remaining;
  assign out_bus.moving    = res_r.moving;
  assign out_bus.stepped   = res_r.stepped;

endmodule

>>> bench/hss_tb_pkg.sv
// Command beat type and result scoreboard for the half-step stepper sequencer bench.
// Depends on hss_pkg for field widths, the mode enum and the result beat struct.
package hss_tb_pkg;
  import hss_pkg::*;

  typedef struct packed {
    hss_mode_t               mode;
    logic                    dir;
    logic [MOVE_STEPS_W-1:0] move_steps;
  } stepper_cmd_t;

  class stepper_scoreboard;
    localparam int CNT_W = DEFAULT_MOVE_COUNT_BITS;
    // Half-step coil sequence, one nibble per phase, phase 0 in the low nibble.
    localparam logic [8*COILS_W-1:0] HALF_STEP_SEQ = 32'h8C46_2319;

    logic [PHASE_W-1:0]    phase;
    logic [POSITION_W-1:0] position;
    logic [CNT_W-1:0]      steps_left;
    logic                  continuous;
    logic                  ccw;
    logic [COILS_W-1:0]    coils;
    hss_result_t           expected_q[$];
    int                    errors;

    function new();
      phase      = '0;
      position   = '0;
      steps_left = '0;
      continuous = 1'b0;
      ccw        = 1'b0;
      coils      = '0;
      errors     = 0;
    endfunction

    // Advance the motor state by one accepted command and queue its result.
    function void note_command(stepper_cmd_t cmd);
      hss_result_t r;
      logic        stepped;
      stepped = 1'b0;
      case (cmd.mode)
        MODE_TICK: begin
          if (continuous || steps_left != '0) begin
            coils   = HALF_STEP_SEQ[phase*COILS_W +: COILS_W];
            stepped = 1'b1;
            if (ccw) begin
              phase    = phase - 1'b1;
              position = position - 1'b1;
            end else begin
              phase    = phase + 1'b1;
              position = position + 1'b1;
            end
            if (steps_left != '0) steps_left = steps_left - 1'b1;
          end
        end
        MODE_START: begin
          ccw        = cmd.dir;
          continuous = 1'b1;
        end
        MODE_STOP: begin
          continuous = 1'b0;
          steps_left = '0;
        end
        default: begin
          ccw        = cmd.dir;
          steps_left = CNT_W'(cmd.move_steps);
        end
      endcase
      r.coils     = coils;
      r.position  = position;
      r.remaining = REMAINING_W'(steps_left);
      r.moving    = continuous || (steps_left != '0);
      r.stepped   = stepped;
      expected_q.push_back(r);
    endfunction

    function void check_result(hss_result_t got);
      hss_result_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with no command pending: coils=%0d position=%0d",
               got.coils, $signed(got.position));
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.coils !== want.coils) begin
        $error("coils: expected %0d, got %0d", want.coils, got.coils);
        errors++;
      end
      if (got.position !== want.position) begin
        $error("position: expected %0d, got %0d", $signed(want.position),
               $signed(got.position));
        errors++;
      end
      if (got.remaining !== want.remaining) begin
        $error("remaining: expected %0d, got %0d", want.remaining, got.remaining);
        errors++;
      end
      if (got.moving !== want.moving) begin
        $error("moving: expected %0b, got %0b", want.moving, got.moving);
        errors++;
      end
      if (got.stepped !== want.stepped) begin
        $error("stepped: expected %0b, got %0b", want.stepped, got.stepped);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

>>> bench/tb_top.sv
// Top-level bench for the half-step stepper sequencer: drives command beats, checks result beats.
// Depends on hss_pkg, hss_channels (hss_cmd_if, hss_res_if), hss_tb_pkg and the RTL top.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hss_pkg::*;
  import hss_tb_pkg::*;

  localparam int RANDOM_ITEMS   = 1700;
  localparam int PRESSURE_ITEMS = 40;
  localparam int HOLD_CYCLES    = 150;
  localparam int CYCLE_LIMIT    = 200000;

  logic clk;
  logic rst_n;

  hss_cmd_if cmd_bus ();
  hss_res_if res_bus ();

  half_step_stepper_sequencer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (cmd_bus),
    .out_bus(res_bus)
  );

  stepper_scoreboard sb = new();

  // Idle knobs, percent per cycle; written by the stimulus process only.
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  // Each bump asks the receiver for one long hold-off.
  int hold_requests = 0;
  int cycle_count   = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Bail out if the run stalls; the limit is far above the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: check each result beat taken at this edge, then pick ready for
  // the next cycle. A hold-off request drops ready for a long stretch that
  // this process counts down itself.
  always @(posedge clk) begin : result_side
    hss_result_t got;
    int          hold_left;
    int          holds_seen;
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
      hold_left  = 0;
      holds_seen = 0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        got.coils     = res_bus.coils;
        got.position  = res_bus.position;
        got.remaining = res_bus.remaining;
        got.moving    = res_bus.moving;
        got.stepped   = res_bus.stepped;
        sb.check_result(got);
      end
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Offer one command beat and hold it until the block takes it. Idle cycles
  // before the beat carry junk payload with valid low, which must be ignored.
  // Call right after a rising edge.
  task automatic send_cmd(input hss_mode_t mode, input logic dir,
                          input logic [MOVE_STEPS_W-1:0] steps);
    stepper_cmd_t c;
    c.mode       = mode;
    c.dir        = dir;
    c.move_steps = steps;
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_bus.valid      <= 1'b0;
      cmd_bus.mode       <= MODE_W'($urandom);
      cmd_bus.dir        <= 1'($urandom);
      cmd_bus.move_steps <= MOVE_STEPS_W'($urandom);
      @(posedge clk);
    end
    cmd_bus.valid      <= 1'b1;
    cmd_bus.mode       <= c.mode;
    cmd_bus.dir        <= c.dir;
    cmd_bus.move_steps <= c.move_steps;
    do @(posedge clk); while (!cmd_bus.ready);
    sb.note_command(c);
  endtask

  // Mostly ticks so that moves run to completion; move counts are short most
  // of the time, with the odd full-range or all-ones count. dir and
  // move_steps are random on every beat, even where the block ignores them.
  task automatic send_random_cmd();
    hss_mode_t                mode;
    logic [MOVE_STEPS_W-1:0]  steps;
    int                       pick;
    pick  = $urandom_range(99);
    steps = MOVE_STEPS_W'($urandom);
    if (pick < 58) begin
      mode = MODE_TICK;
    end else if (pick < 68) begin
      mode = MODE_START;
    end else if (pick < 76) begin
      mode = MODE_STOP;
    end else begin
      mode = MODE_MOVE;
      case ($urandom_range(9))
        0:       steps = MOVE_STEPS_W'($urandom);
        1:       steps = '1;
        default: steps = MOVE_STEPS_W'($urandom_range(24));
      endcase
    end
    send_cmd(mode, 1'($urandom), steps);
  endtask

  // Drop valid and hold until every expected result beat has come back.
  task automatic drain();
    cmd_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int tx_pct[4];
    int rx_pct[4];
    tx_pct = '{0, 53, 0, 24};
    rx_pct = '{0, 0, 53, 24};

    rst_n              <= 1'b0;
    cmd_bus.valid      <= 1'b0;
    cmd_bus.mode       <= MODE_TICK;
    cmd_bus.dir        <= 1'b0;
    cmd_bus.move_steps <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, no idling.
    // Tick from reset: nothing to do, coils stay off, dir ignored.
    send_cmd(MODE_TICK, 1'b1, 16'hFFFF);
    // Zero-count move: latches direction, no motion.
    send_cmd(MODE_MOVE, 1'b1, 16'h0000);
    send_cmd(MODE_TICK, 1'b0, 16'h0000);
    // Continuous clockwise: one full lap plus the phase wrap from 7 to 0.
    send_cmd(MODE_START, 1'b0, 16'hA5A5);
    repeat (9) send_cmd(MODE_TICK, 1'b1, 16'h0000);
    // Stop ignores dir; the next tick must not step and coils hold.
    send_cmd(MODE_STOP, 1'b1, 16'hFFFF);
    send_cmd(MODE_TICK, 1'b0, 16'h0000);
    // Counted move backward across phase 0, then one tick with nothing left.
    send_cmd(MODE_MOVE, 1'b1, 16'd3);
    repeat (4) send_cmd(MODE_TICK, 1'b0, 16'h5A5A);
    // Largest count, then continuous on top of a pending count with a flip.
    send_cmd(MODE_MOVE, 1'b1, 16'hFFFF);
    send_cmd(MODE_TICK, 1'b0, 16'h0000);
    send_cmd(MODE_START, 1'b0, 16'h0000);
    send_cmd(MODE_TICK, 1'b1, 16'h0000);
    send_cmd(MODE_STOP, 1'b0, 16'h0000);
    send_cmd(MODE_MOVE, 1'b0, 16'h8000);
    send_cmd(MODE_TICK, 1'b1, 16'h0000);
    send_cmd(MODE_STOP, 1'b1, 16'h0000);
    drain();

    // Random part, one idle setting per phase, drained between phases.
    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct  = tx_pct[ph];
      rx_stall_pct = rx_pct[ph];
      repeat (RANDOM_ITEMS / 4) send_random_cmd();
      drain();
      if (ph == 0) begin
        // Back-pressure: receiver holds off while the sender keeps offering,
        // so the result register fills and the command channel stalls.
        hold_requests = hold_requests + 1;
        repeat (PRESSURE_ITEMS) send_random_cmd();
        drain();
      end
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/hss_pkg.sv
src/hss_channels.sv
src/hss_motor_state.sv
src/half_step_stepper_sequencer.sv
bench/hss_tb_pkg.sv
bench/tb_top.sv
